/* hw/rtl/hdwt_pkg.sv */
// Package with the shared constants and types of the Haar wavelet stream core.
`timescale 1ns / 1ps

package hdwt_pkg;

  // Sample and coefficient width.
  localparam int unsigned SampleW = 8;
  // Width of the boundary extension register.
  localparam int unsigned ModeW = 3;
  // Width of a multiplier operand; it holds 3x - p for any two samples.
  localparam int unsigned OpW = 11;
  // Width of the signed constant multiplier.
  localparam int unsigned ScaleW = 8;
  // Width of a product, wide enough for any operand times the scale.
  localparam int unsigned ProdW = OpW + ScaleW;
  // The scale 91/128 approximates 1/sqrt(2).
  localparam logic signed [ScaleW-1:0] HaarScale = 8'sd91;
  localparam int unsigned ScaleShift = 7;

  typedef enum logic [ModeW-1:0] {
    ExtZero          = 3'd0,
    ExtConstant      = 3'd1,
    ExtSymmetric     = 3'd2,
    ExtReflect       = 3'd3,
    ExtAntisymmetric = 3'd4,
    ExtAntireflect   = 3'd5,
    ExtPeriodic      = 3'd6
  } ext_mode_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [OpW-1:0]     operand_t;
  typedef logic signed [ProdW-1:0]   product_t;

endpackage

/* hw/rtl/haar_dwt_q8_stream_core.sv */
// One-level Haar wavelet transform over a stream of signed Q7 samples.
`timescale 1ns / 1ps

// The core takes one signed Q7 sample per transaction, together with a flag
// that marks the last sample of a signal, and returns one coefficient pair
// (approximation and detail, both scaled by 91/128 and wrapped to 8 bits)
// for every odd-index sample. When a signal has odd length, its final sample
// yields one extra tail pair whose value follows the boundary extension mode
// held in the configuration register; periodic mode and the unused code 7
// behave as zero extension. The final_pair flag is set on the pair caused by
// the last sample of a signal, after which the core starts a fresh signal.
// The pair is formed by two constant multiplications between the held-sample
// state and a single output register, so a new sample is accepted in every
// cycle while the output side keeps up, and a stalled result blocks the input
// only while it is held in that register. The result of an accepted sample
// is in the output register in the following cycle.
// The extension mode should only be changed while no signal is in flight.
module haar_dwt_q8_stream_core
  import hdwt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration register write port.
  input  logic               cfg_wr_en_i,
  input  logic [ModeW-1:0]   cfg_wr_data_i,
  // Sample input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic               is_last_i,
  // Coefficient output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [SampleW-1:0] approx_o,
  output logic signed [SampleW-1:0] detail_o,
  output logic               final_pair_o
);

  // Configuration and signal state.
  logic [ModeW-1:0] mode_q;
  sample_t          held_q, held_d;
  logic             odd_q, odd_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  sample_t          approx_q, approx_d;
  sample_t          detail_q, detail_d;
  logic             final_q, final_d;

  logic     in_fire;
  logic     emit;
  operand_t cur_ext, held_ext;
  operand_t lo_op, hi_op;
  product_t lo_prod, hi_prod;

  // The output register is free when empty or when its result leaves now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // A transaction gives a result on an odd-index sample, or on any last one.
  assign emit = odd_q || is_last_i;

  assign cur_ext  = OpW'(sample_i);
  assign held_ext = OpW'(held_q);

  // Select the multiplier operands. For a pair the held sample is the even
  // partner; for a tail the held sample is the one before the final sample.
  always_comb begin
    lo_op = held_ext + cur_ext;
    hi_op = held_ext - cur_ext;
    if (!odd_q) begin
      unique case (mode_q)
        ExtConstant, ExtSymmetric: begin
          lo_op = cur_ext <<< 1;
          hi_op = '0;
        end
        ExtReflect: begin
          lo_op = cur_ext + held_ext;
          hi_op = cur_ext - held_ext;
        end
        ExtAntisymmetric: begin
          lo_op = '0;
          hi_op = cur_ext <<< 1;
        end
        ExtAntireflect: begin
          lo_op = (cur_ext <<< 1) + cur_ext - held_ext;
          hi_op = held_ext - cur_ext;
        end
        default: begin
          // Zero, periodic and the unused code all use the sample alone.
          lo_op = cur_ext;
          hi_op = cur_ext;
        end
      endcase
    end
  end

  // Products never exceed the product width, so the coefficient is simply
  // the byte just above the scale shift, for pairs and tails alike.
  assign lo_prod = ProdW'(lo_op) * ProdW'(HaarScale);
  assign hi_prod = ProdW'(hi_op) * ProdW'(HaarScale);

  always_comb begin
    held_d      = held_q;
    odd_d       = odd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    approx_d    = approx_q;
    detail_d    = detail_q;
    final_d     = final_q;
    if (in_fire) begin
      if (is_last_i) begin
        // The end of a signal clears the state for the next one.
        held_d = '0;
        odd_d  = 1'b0;
      end else begin
        held_d = sample_i;
        odd_d  = !odd_q;
      end
      if (emit) begin
        out_valid_d = 1'b1;
        approx_d    = lo_prod[ScaleShift +: SampleW];
        detail_d    = hi_prod[ScaleShift +: SampleW];
        final_d     = is_last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ExtZero;
      held_q      <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        mode_q <= cfg_wr_data_i;
      end
      held_q      <= held_d;
      odd_q       <= odd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    approx_q <= approx_d;
    detail_q <= detail_d;
    final_q  <= final_d;
  end

  assign out_valid_o  = out_valid_q;
  assign approx_o     = approx_q;
  assign detail_o     = detail_q;
  assign final_pair_o = final_q;

  // An empty output register never holds back the input.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty output register");

  // Every odd-index or last sample leaves a result in the output register.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit |=> out_valid_q && (final_q == $past(is_last_i)))
    else $error("accepted sample did not produce its coefficient pair");

  // A last sample always returns the core to the start of a signal.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_last_i |=> !odd_q && (held_q == '0))
    else $error("signal state not cleared after the last sample");

  // A held even sample moves the core to the odd position.
  a_even_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !odd_q && !is_last_i |=> odd_q && (held_q == $past(sample_i)))
    else $error("even-index sample not held");

endmodule

/* tb/sv/tb_haar_dwt_q8_stream_core.sv */
// Self-checking testbench for the Haar wavelet stream core.
`timescale 1ns / 1ps

// The bench sends whole signals of signed Q7 samples, each closed by a sample
// with the last flag, into the core. A predictor inside the bench works out
// the coefficient pair that each accepted sample should give. The predictor
// keeps its own copy of the held sample, the index parity and the extension
// mode. A monitor compares every coefficient transaction, field by field,
// with the oldest pair still waiting.
//
// The run is split into phases. A phase is a batch of complete signals sent
// under one extension mode. Between phases the sender pauses until every
// expected pair has arrived. Only then is the mode register rewritten, so
// the mode never changes while a signal is in flight.
module tb_haar_dwt_q8_stream_core
  import hdwt_pkg::*;
();

  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned ResetLen   = 10;
  // Cycles of the long output hold-off, well beyond the single result slot.
  localparam int unsigned HoldCycles = 300;
  // Chance in a hundred that either side idles in a cycle.
  localparam int unsigned IdlePct    = 27;
  localparam int unsigned PhaseItems = 55;
  localparam int unsigned Rounds     = 3;
  // Any run past this limit is taken as a hang.
  localparam int unsigned CycleLimit = 200000;
  // The register is three bits wide, so code 7 can be written although the
  // package names no mode for it. It must behave as zero extension.
  localparam logic [ModeW-1:0] ExtUnused = 3'd7;

  typedef struct packed {
    sample_t smp;
    logic    is_last;
  } sample_item_t;

  typedef struct packed {
    sample_t approx;
    sample_t detail;
    logic    final_pair;
  } coef_pair_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_wr_en    = 1'b0;
  logic [ModeW-1:0] cfg_wr_data  = '0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  sample_t          in_sample    = '0;
  logic             in_last      = 1'b0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  sample_t          approx;
  sample_t          detail;
  logic             final_pair;

  // Samples waiting to be offered, and pairs waiting to be observed.
  sample_item_t pending_samples[$];
  coef_pair_t   expected_pairs[$];

  // The predictor's copy of the core's state and of its mode register.
  sample_t          held_q = '0;
  logic             odd_q  = 1'b0;
  logic [ModeW-1:0] mode_q = ExtZero;

  // The stall request is set on a falling edge and consumed on a rising
  // one. The steady flag switches off random idling on both sides.
  bit          stall_request = 1'b0;
  bit          steady        = 1'b0;
  int unsigned hold_left     = 0;

  int unsigned fail_cnt      = 0;
  int unsigned samples_taken = 0;
  int unsigned pairs_checked = 0;
  int unsigned tails_seen    = 0;
  int unsigned phase_cnt     = 0;
  int unsigned cycle_cnt     = 0;

  haar_dwt_q8_stream_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (in_sample),
    .is_last_i     (in_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .approx_o      (approx),
    .detail_o      (detail),
    .final_pair_o  (final_pair)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Scales an operand by 91/128. The product is first wrapped to 16 bits,
  // then shifted arithmetically and wrapped to the coefficient width. Every
  // ordinary pair product fits in 16 bits, so the wrap only ever bites on
  // the wider tail operands.
  function automatic sample_t scale_wrap(input int operand);
    shortint prod;
    prod = shortint'(operand * HaarScale);
    return sample_t'(prod >>> ScaleShift);
  endfunction

  // Advances the predicted state by one sample. Returns 1 when the sample
  // yields a coefficient pair, which is then passed back through pair.
  function automatic bit haar_predict(input sample_t cur, input logic is_last,
                                      output coef_pair_t pair);
    int p;
    int c;
    int lo;
    int hi;
    p    = held_q;
    c    = cur;
    pair = '0;
    if (odd_q) begin
      // An odd-index sample closes a pair with the sample held before it.
      pair.approx     = scale_wrap(p + c);
      pair.detail     = scale_wrap(p - c);
      pair.final_pair = is_last;
      held_q          = is_last ? sample_t'(0) : cur;
      odd_q           = 1'b0;
      return 1'b1;
    end
    if (!is_last) begin
      // An even-index sample in mid-signal is only held.
      held_q = cur;
      odd_q  = 1'b1;
      return 1'b0;
    end
    // The last sample of an odd-length signal gives a tail pair whose
    // value depends on the boundary extension.
    case (mode_q)
      ExtConstant, ExtSymmetric: begin
        lo = 2 * c;
        hi = 0;
      end
      ExtReflect: begin
        lo = c + p;
        hi = c - p;
      end
      ExtAntisymmetric: begin
        lo = 0;
        hi = 2 * c;
      end
      ExtAntireflect: begin
        lo = 3 * c - p;
        hi = p - c;
      end
      default: begin
        // Zero, periodic and the unused code all take the sample alone.
        lo = c;
        hi = c;
      end
    endcase
    pair.approx     = scale_wrap(lo);
    pair.detail     = scale_wrap(hi);
    pair.final_pair = 1'b1;
    held_q          = '0;
    odd_q           = 1'b0;
    tails_seen++;
    return 1'b1;
  endfunction

  // Sample driver. When a transaction completes, the predictor is fed the
  // sample that was on the bus. A new sample is offered only once the
  // previous one has gone, so valid and the payload stay put while the
  // core stalls.
  always @(posedge clk) begin : drive_samples
    coef_pair_t   pair;
    sample_item_t item;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        samples_taken++;
        if (haar_predict(in_sample, in_last, pair)) begin
          expected_pairs.push_back(pair);
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          item = pending_samples.pop_front();
          in_valid  <= 1'b1;
          in_sample <= item.smp;
          in_last   <= item.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Coefficient monitor. It also decides the ready for the next cycle. A
  // requested hold-off is counted down here while the sender keeps
  // offering samples, so the result slot fills and the input stalls.
  always @(posedge clk) begin : check_pairs
    coef_pair_t want;
    if (out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        $error("coefficient transaction with no pair expected: approx %0d detail %0d",
               approx, detail);
        fail_cnt++;
      end else begin
        want = expected_pairs.pop_front();
        pairs_checked++;
        if (approx !== want.approx) begin
          $error("approx: expected %0d, actual %0d", want.approx, approx);
          fail_cnt++;
        end
        if (detail !== want.detail) begin
          $error("detail: expected %0d, actual %0d", want.detail, detail);
          fail_cnt++;
        end
        if (final_pair !== want.final_pair) begin
          $error("final_pair: expected %0b, actual %0b", want.final_pair, final_pair);
          fail_cnt++;
        end
      end
    end
    if (stall_request) begin
      hold_left     = HoldCycles;
      stall_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // Watchdog. A hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d pairs outstanding.",
               cycle_cnt, expected_pairs.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Queues one complete signal. The final sample carries the last flag.
  task automatic add_signal(input int vals[$]);
    foreach (vals[i]) begin
      pending_samples.push_back('{smp: sample_t'(vals[i]), is_last: (i == vals.size() - 1)});
    end
  endtask

  // Random samples lean towards the extremes, where the wrap shows.
  function automatic int pick_sample();
    case ($urandom_range(9))
      0:       return -128;
      1:       return 127;
      2:       return 0;
      3:       return -1;
      default: return $signed(8'($urandom()));
    endcase
  endfunction

  // Fills one phase with whole signals. Mostly short ones, some of length
  // one, and now and then a long one.
  task automatic fill_phase(input int unsigned n_items);
    int unsigned queued;
    int unsigned len;
    int unsigned pick;
    int          vals[$];
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = 1;
      end else if (pick < 85) begin
        len = $urandom_range(9, 2);
      end else begin
        len = $urandom_range(40, 10);
      end
      vals.delete();
      repeat (len) vals.push_back(pick_sample());
      add_signal(vals);
      queued += len;
    end
  endtask

  // Pauses the sender until no sample is pending or on the bus and every
  // expected pair has been seen. Since each signal ends in a sample that gives
  // a pair, the core then holds no signal when the mode register is touched.
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_pairs.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic [ModeW-1:0] mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    mode_q       = mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : run_phases
    logic [ModeW-1:0] mode;
    repeat (ResetLen) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed signals under the reset mode, which is zero extension: the
    // one-sample signals, the overflow of sum and difference at the sample
    // extremes, and odd-length tails with and without a held sample.
    add_signal('{127});
    add_signal('{-128});
    add_signal('{127, 127});
    add_signal('{-128, -128});
    add_signal('{127, -128});
    add_signal('{-128, 127});
    add_signal('{0, -1, 1});
    add_signal('{-1, 0, 5, -7});
    add_signal('{127, -128, 127, -128, -128});
    drain();
    phase_cnt++;

    // The first round walks through every mode code in order. Later rounds
    // pick them at random. One phase runs without idling on either side,
    // and two phases start with a long output hold-off.
    for (int unsigned r = 0; r < Rounds; r++) begin
      for (int unsigned k = 0; k < 8; k++) begin
        mode = (r == 0) ? ModeW'(k) : ModeW'($urandom_range(ExtUnused));
        write_mode(mode);
        @(negedge clk);
        steady = (r == 1 && k == 0);
        if ((r == 0 && k == 2) || (r == 2 && k == 5)) begin
          stall_request = 1'b1;
        end
        fill_phase(PhaseItems);
        drain();
        phase_cnt++;
      end
    end
    steady = 1'b0;

    // Leave room for any result that is late past the drain.
    repeat (10) @(posedge clk);
    if (expected_pairs.size() != 0) begin
      $error("%0d expected coefficient pairs never arrived", expected_pairs.size());
      fail_cnt++;
    end

    $display("Run covered %0d samples and %0d coefficient pairs, %0d of them tails,",
             samples_taken, pairs_checked, tails_seen);
    $display("over %0d phases using all eight mode codes, with random stalls and hold-offs.",
             phase_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
